FILE: rtl/ecal_pkg.sv
// ----------------------------------------------------------------------------
// ecal_pkg
// Shared types and constants for the epoch-seconds to calendar converter:
// epoch selector codes, offsets, constant divisors with their reciprocals,
// and the table of month start days within a four-year block.
// ----------------------------------------------------------------------------
package ecal_pkg;

  localparam int NUM_STAGES = 7;

  // Pipeline stage load enables, bit 0 is the first stage, top bit the output.
  typedef struct packed {
    logic [NUM_STAGES-1:0] load;
  } pipe_ctl_t;

  // Epoch selector codes.
  localparam logic [1:0] EPOCH_Y2000 = 2'd0;
  localparam logic [1:0] EPOCH_Y2012 = 2'd1;
  localparam logic [1:0] EPOCH_UNIX  = 2'd2;
  localparam logic [1:0] EPOCH_Y1996 = 2'd3;

  localparam logic [31:0] OFS_Y2012 = 32'd378691200;
  localparam logic [31:0] OFS_UNIX  = 32'd946684800;
  localparam logic [31:0] OFS_Y1996 = 32'd126230400;

  // Divisors and floor(2^k / d) reciprocals. Each estimate is at most one low.
  localparam logic [16:0] SEC_PER_DAY  = 17'd86400;
  localparam logic [22:0] DAY_RECIP    = 23'd6362914;  // 2^32 / 675, on secs >> 7
  localparam logic [10:0] BLOCK_DAYS   = 11'd1461;
  localparam logic [5:0]  BLOCK_RECIP  = 6'd44;        // 2^16 / 1461
  localparam logic [11:0] SEC_PER_HOUR = 12'd3600;
  localparam logic [5:0]  HOUR_RECIP   = 6'd36;        // 2^17 / 3600
  localparam logic [5:0]  SEC_PER_MIN  = 6'd60;
  localparam logic [6:0]  MIN_RECIP    = 7'd68;        // 2^12 / 60

  // Day of the four-year block on which each month begins. Year 0 is leap.
  localparam logic [10:0] MONTH_START [0:3][0:11] = '{
    '{11'd0,    11'd31,   11'd60,   11'd91,   11'd121,  11'd152,
      11'd182,  11'd213,  11'd244,  11'd274,  11'd305,  11'd335},
    '{11'd366,  11'd397,  11'd425,  11'd456,  11'd486,  11'd517,
      11'd547,  11'd578,  11'd609,  11'd639,  11'd670,  11'd700},
    '{11'd731,  11'd762,  11'd790,  11'd821,  11'd851,  11'd882,
      11'd912,  11'd943,  11'd974,  11'd1004, 11'd1035, 11'd1065},
    '{11'd1096, 11'd1127, 11'd1155, 11'd1186, 11'd1216, 11'd1247,
      11'd1277, 11'd1308, 11'd1339, 11'd1369, 11'd1400, 11'd1430}
  };

endpackage

FILE: rtl/ecal_datapath.sv
// ----------------------------------------------------------------------------
// ecal_datapath
// Seven-stage conversion datapath: epoch shift, split into days and seconds
// of day by reciprocal multiply and correction, then blocks, hours, minutes,
// year within block and month lookup.
// ----------------------------------------------------------------------------
module ecal_datapath (
  input  logic                clk,
  input  ecal_pkg::pipe_ctl_t ctl,
  input  logic [31:0]         timestamp,
  input  logic [1:0]          epoch_base,
  output logic [7:0]          year_offset,
  output logic [3:0]          month_number,
  output logic [4:0]          day_of_month,
  output logic [4:0]          hours,
  output logic [5:0]          minutes,
  output logic [5:0]          seconds_part
);

  // stage 1
  logic [31:0] s1_secs, s1_secs_next;
  // stage 2
  logic [31:0] s2_secs;
  logic [15:0] s2_days_est;
  logic [47:0] day_est_prod;
  // stage 3
  logic [15:0] s3_days, s3_days_next;
  logic [16:0] s3_sod, s3_sod_next;
  logic [32:0] day_back;
  logic [31:0] day_rem;
  logic [17:0] day_rem_n;
  // stage 4
  logic [15:0] s4_days;
  logic [16:0] s4_sod;
  logic [5:0]  s4_blk_est;
  logic [4:0]  s4_hr_est;
  logic [21:0] blk_est_prod;
  logic [22:0] hr_est_prod;
  // stage 5
  logic [5:0]  s5_blocks, s5_blocks_next;
  logic [10:0] s5_dib, s5_dib_next;
  logic [4:0]  s5_hr, s5_hr_next;
  logic [11:0] s5_soh, s5_soh_next;
  logic [16:0] blk_back;
  logic [11:0] blk_rem;
  logic [16:0] hr_back;
  logic [12:0] hr_rem;
  // stage 6
  logic [5:0]  s6_blocks;
  logic [10:0] s6_dib;
  logic [1:0]  s6_yr, s6_yr_next;
  logic [4:0]  s6_hr;
  logic [11:0] s6_soh;
  logic [5:0]  s6_min_est;
  logic [18:0] min_est_prod;
  // stage 7 (output)
  logic [3:0]  mo_idx;
  logic [10:0] mo_start;
  logic [10:0] dom_full;
  logic [11:0] min_back;
  logic [6:0]  min_rem;
  logic [5:0]  min_next, sec_next;

  // Stage 1: shift to the 2000 epoch, wrapping mod 2^32.
  always_comb begin
    unique case (epoch_base)
      ecal_pkg::EPOCH_Y2012: s1_secs_next = timestamp + ecal_pkg::OFS_Y2012;
      ecal_pkg::EPOCH_UNIX:  s1_secs_next = timestamp - ecal_pkg::OFS_UNIX;
      ecal_pkg::EPOCH_Y1996: s1_secs_next = timestamp - ecal_pkg::OFS_Y1996;
      default:               s1_secs_next = timestamp;
    endcase
  end

  // Stage 2: day estimate, divide by 128 then by 675.
  assign day_est_prod = 48'(s1_secs[31:7]) * 48'(ecal_pkg::DAY_RECIP);

  // Stage 3: remainder and one-step correction.
  assign day_back  = 33'(s2_days_est) * 33'(ecal_pkg::SEC_PER_DAY);
  assign day_rem   = s2_secs - day_back[31:0];
  assign day_rem_n = day_rem[17:0];
  always_comb begin
    if (day_rem_n >= 18'(ecal_pkg::SEC_PER_DAY)) begin
      s3_days_next = s2_days_est + 16'd1;
      s3_sod_next  = 17'(day_rem_n - 18'(ecal_pkg::SEC_PER_DAY));
    end else begin
      s3_days_next = s2_days_est;
      s3_sod_next  = day_rem_n[16:0];
    end
  end

  // Stage 4: block and hour estimates.
  assign blk_est_prod = 22'(s3_days) * 22'(ecal_pkg::BLOCK_RECIP);
  assign hr_est_prod  = 23'(s3_sod) * 23'(ecal_pkg::HOUR_RECIP);

  // Stage 5: remainders and corrections.
  assign blk_back = 17'(s4_blk_est) * 17'(ecal_pkg::BLOCK_DAYS);
  assign blk_rem  = 12'(s4_days - blk_back[15:0]);
  assign hr_back  = 17'(s4_hr_est) * 17'(ecal_pkg::SEC_PER_HOUR);
  assign hr_rem   = 13'(s4_sod - hr_back);
  always_comb begin
    if (blk_rem >= 12'(ecal_pkg::BLOCK_DAYS)) begin
      s5_blocks_next = s4_blk_est + 6'd1;
      s5_dib_next    = 11'(blk_rem - 12'(ecal_pkg::BLOCK_DAYS));
    end else begin
      s5_blocks_next = s4_blk_est;
      s5_dib_next    = blk_rem[10:0];
    end
    if (hr_rem >= 13'(ecal_pkg::SEC_PER_HOUR)) begin
      s5_hr_next  = s4_hr_est + 5'd1;
      s5_soh_next = 12'(hr_rem - 13'(ecal_pkg::SEC_PER_HOUR));
    end else begin
      s5_hr_next  = s4_hr_est;
      s5_soh_next = hr_rem[11:0];
    end
  end

  // Stage 6: year within block, minute estimate.
  always_comb begin
    if (s5_dib >= ecal_pkg::MONTH_START[3][0]) begin
      s6_yr_next = 2'd3;
    end else if (s5_dib >= ecal_pkg::MONTH_START[2][0]) begin
      s6_yr_next = 2'd2;
    end else if (s5_dib >= ecal_pkg::MONTH_START[1][0]) begin
      s6_yr_next = 2'd1;
    end else begin
      s6_yr_next = 2'd0;
    end
  end
  assign min_est_prod = 19'(s5_soh) * 19'(ecal_pkg::MIN_RECIP);

  // Stage 7: month search on the selected row, minute correction.
  always_comb begin
    mo_idx = 4'd0;
    for (int j = 1; j < 12; j++) begin
      if (s6_dib >= ecal_pkg::MONTH_START[s6_yr][j]) mo_idx = 4'(j);
    end
  end
  assign mo_start = ecal_pkg::MONTH_START[s6_yr][mo_idx];
  assign dom_full = 11'(s6_dib - mo_start) + 11'd1;

  assign min_back = 12'(s6_min_est) * 12'(ecal_pkg::SEC_PER_MIN);
  assign min_rem  = 7'(s6_soh - min_back);
  always_comb begin
    if (min_rem >= 7'(ecal_pkg::SEC_PER_MIN)) begin
      min_next = s6_min_est + 6'd1;
      sec_next = 6'(min_rem - 7'(ecal_pkg::SEC_PER_MIN));
    end else begin
      min_next = s6_min_est;
      sec_next = min_rem[5:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load[0]) begin
      s1_secs <= s1_secs_next;
    end
    if (ctl.load[1]) begin
      s2_secs     <= s1_secs;
      s2_days_est <= day_est_prod[47:32];
    end
    if (ctl.load[2]) begin
      s3_days <= s3_days_next;
      s3_sod  <= s3_sod_next;
    end
    if (ctl.load[3]) begin
      s4_days    <= s3_days;
      s4_sod     <= s3_sod;
      s4_blk_est <= blk_est_prod[21:16];
      s4_hr_est  <= hr_est_prod[21:17];
    end
    if (ctl.load[4]) begin
      s5_blocks <= s5_blocks_next;
      s5_dib    <= s5_dib_next;
      s5_hr     <= s5_hr_next;
      s5_soh    <= s5_soh_next;
    end
    if (ctl.load[5]) begin
      s6_blocks  <= s5_blocks;
      s6_dib     <= s5_dib;
      s6_yr      <= s6_yr_next;
      s6_hr      <= s5_hr;
      s6_soh     <= s5_soh;
      s6_min_est <= min_est_prod[17:12];
    end
    if (ctl.load[6]) begin
      year_offset  <= {s6_blocks, s6_yr};
      month_number <= mo_idx + 4'd1;
      day_of_month <= dom_full[4:0];
      hours        <= s6_hr;
      minutes      <= min_next;
      seconds_part <= sec_next;
    end
  end

endmodule

FILE: rtl/epoch_seconds_to_calendar_top.sv
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar_top
// Converts a 32-bit second count into year/month/day/hour/minute/second
// counted from 1 Jan 2000, after an optional fixed epoch shift.
// ----------------------------------------------------------------------------
// Takes one timestamp word per cycle while ts_stall is low and returns one
// calendar word per word taken, in order. The result word moves through the
// seven pipeline registers in order, the first of which loads at the edge
// that accepts its input word. The stages are epoch shift, a reciprocal
// multiply and a correction step for the split into days, one more
// multiply/correct pair for four-year blocks and hours, then the year
// compare, month table search and minute split.
// Stages that hold no word fill while the output is stalled, so up to seven
// words queue up before ts_stall rises. Every fourth year is a leap year,
// 2100 included; a timestamp before the chosen epoch wraps to a late date.
module epoch_seconds_to_calendar_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        ts_valid,
  output logic        ts_stall,
  input  logic [31:0] timestamp,
  input  logic [1:0]  epoch_base,
  output logic        cal_valid,
  input  logic        cal_stall,
  output logic [7:0]  year_offset,
  output logic [3:0]  month_number,
  output logic [4:0]  day_of_month,
  output logic [4:0]  hours,
  output logic [5:0]  minutes,
  output logic [5:0]  seconds_part
);

  localparam int N = ecal_pkg::NUM_STAGES;

  logic [N-1:0]        stage_vld, stage_vld_next;
  logic [N-1:0]        stage_rdy;
  ecal_pkg::pipe_ctl_t ctl;

  // A stage takes a new word when it is empty or its word moves on.
  always_comb begin
    stage_rdy[N-1] = ~stage_vld[N-1] | ~cal_stall;
    for (int i = N - 2; i >= 0; i--) begin
      stage_rdy[i] = ~stage_vld[i] | stage_rdy[i+1];
    end
  end

  always_comb begin
    stage_vld_next[0] = stage_rdy[0] ? ts_valid : stage_vld[0];
    for (int i = 1; i < N; i++) begin
      stage_vld_next[i] = stage_rdy[i] ? stage_vld[i-1] : stage_vld[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_vld <= '0;
    end else begin
      stage_vld <= stage_vld_next;
    end
  end

  assign ctl.load  = stage_rdy;
  assign ts_stall  = ~stage_rdy[0];
  assign cal_valid = stage_vld[N-1];

  ecal_datapath u_datapath (
    .clk          (clk),
    .ctl          (ctl),
    .timestamp    (timestamp),
    .epoch_base   (epoch_base),
    .year_offset  (year_offset),
    .month_number (month_number),
    .day_of_month (day_of_month),
    .hours        (hours),
    .minutes      (minutes),
    .seconds_part (seconds_part)
  );

endmodule

FILE: rtl/ecal_check.sv
// ----------------------------------------------------------------------------
// ecal_check
// Port-level checks for the calendar converter, bound to the top level.
// ----------------------------------------------------------------------------
module ecal_check (
  input logic        clk,
  input logic        rst,
  input logic        cal_valid,
  input logic        cal_stall,
  input logic [7:0]  year_offset,
  input logic [3:0]  month_number,
  input logic [4:0]  day_of_month,
  input logic [4:0]  hours,
  input logic [5:0]  minutes,
  input logic [5:0]  seconds_part
);

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    cal_valid && cal_stall |=> cal_valid)
    else $error("result word dropped while stalled");

  a_hold_word: assert property (@(posedge clk) disable iff (rst)
    cal_valid && cal_stall |=> $stable({year_offset, month_number, day_of_month,
                                        hours, minutes, seconds_part}))
    else $error("stalled result word changed");

  a_empty_after_reset: assert property (@(posedge clk)
    rst |=> !cal_valid)
    else $error("result valid right after reset");

  a_date_range: assert property (@(posedge clk) disable iff (rst)
    cal_valid |-> month_number >= 4'd1 && month_number <= 4'd12 &&
                  day_of_month >= 5'd1 && year_offset <= 8'd139)
    else $error("date field out of range");

  a_time_range: assert property (@(posedge clk) disable iff (rst)
    cal_valid |-> hours <= 5'd23 && minutes <= 6'd59 && seconds_part <= 6'd59)
    else $error("time field out of range");

endmodule

bind epoch_seconds_to_calendar_top ecal_check u_check (.*);
